// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked at every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a rising edge of clk.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/olst_pkg.sv =====
// ---------------------------------------------------------------------------
// olst_pkg
// Types, codes and default sizes shared by the ordered list store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package olst_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 8;
    localparam int COUNT_W  = 9;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_FIND       = 3'd6,
        OP_MODIFY     = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_RANGE    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

endpackage

// ===== rtl/core/olst_ram.sv =====
// ---------------------------------------------------------------------------
// olst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module olst_ram #(
    parameter int WIDTH = olst_pkg::DATA_WIDTH,
    parameter int DEPTH = olst_pkg::CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import olst_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ordered_list_store.sv =====
// ---------------------------------------------------------------------------
// ordered_list_store
// Fixed-capacity ordered list of signed words held in one RAM, with push,
// pop, insert, remove, find and modify requests.
//
//   Channel   Dir   Handshake              Beat contents
//   request   in    start & !busy          op, position, item_value
//   result    out   done (one cycle)       status, found_index, element_count
//
// Push back, pop back, modify and every rejected request return their beat in
// the cycle after acceptance, and busy stays low.
// Push front, insert, remove, pop front and find walk the list one entry per
// cycle through the single RAM read port, each entry shifted and written back
// or compared; find stops at the first match.
// Reset clears only the count and control state; no clearing pass is run.
// Results cannot be stalled; busy holds off new requests while a walk runs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ordered_list_store #(
    parameter int CAPACITY   = olst_pkg::CAPACITY,
    parameter int DATA_WIDTH = olst_pkg::DATA_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [olst_pkg::OP_W-1:0]           op,
    input  logic [olst_pkg::POS_W-1:0]          position,
    input  logic signed [olst_pkg::VALUE_W-1:0] item_value,
    output logic                                done,
    output logic [olst_pkg::STATUS_W-1:0]       status,
    output logic [olst_pkg::FOUND_W-1:0]        found_index,
    output logic [olst_pkg::COUNT_W-1:0]        element_count
);
    import olst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    typedef enum logic [1:0] {
        MV_UP,
        MV_DOWN,
        MV_FIND
    } mode_t;

    state_t                  state_reg;
    mode_t                   mode_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           rem_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic                    pend_reg;
    logic [AW-1:0]           pend_addr_reg;
    logic [AW-1:0]           pos_reg;
    logic [DATA_WIDTH-1:0]   val_reg;
    logic                    done_reg;
    status_t                 status_reg;
    logic [FOUND_W-1:0]      found_reg;
    logic [COUNT_W-1:0]      result_count_reg;

    logic                    accept;
    logic signed [63:0]      val_ext;
    logic [DATA_WIDTH-1:0]   val_in;
    logic [XW-1:0]           pos_x;
    logic [XW-1:0]           count_x;
    logic                    pos_ok;
    logic                    is_full;
    logic                    is_empty;
    logic [AW-1:0]           pos_a;
    logic [AW-1:0]           count_a;
    logic [AW-1:0]           count_m1_a;
    logic [CW-1:0]           count_inc;
    logic [CW-1:0]           count_dec;
    logic [CW-1:0]           pos_c;
    logic                    issue;
    logic                    match;
    logic                    drain;
    logic [AW-1:0]           rd_next;
    logic [AW-1:0]           pend_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic [DATA_WIDTH-1:0]   ram_rdata;

    assign accept     = start && !busy;
    assign val_ext    = 64'(item_value);
    assign val_in     = val_ext[DATA_WIDTH-1:0];
    assign pos_x      = XW'(position);
    assign count_x    = XW'(count_reg);
    assign pos_ok     = pos_x < count_x;
    assign is_full    = count_reg == CW'(CAPACITY);
    assign is_empty   = count_reg == '0;
    assign pos_a      = AW'(position);
    assign count_a    = AW'(count_reg);
    assign count_m1_a = AW'(count_reg - 1'b1);
    assign count_inc  = count_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;
    assign pos_c      = CW'(pos_x);

    assign issue = (state_reg == S_RUN) && (rem_reg != '0);
    assign match = (state_reg == S_RUN) && pend_reg && (mode_reg == MV_FIND)
                   && (ram_rdata == val_reg);
    assign drain = (state_reg == S_RUN) && (rem_reg == '0) && !pend_reg;

    always_comb
    begin
        case (mode_reg)
            MV_UP:
            begin
                rd_next   = rd_addr_reg - AW'(1);
                pend_next = rd_addr_reg + AW'(1);
            end
            MV_DOWN:
            begin
                rd_next   = rd_addr_reg + AW'(1);
                pend_next = rd_addr_reg - AW'(1);
            end
            default:
            begin
                rd_next   = rd_addr_reg + AW'(1);
                pend_next = rd_addr_reg;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        if ((state_reg == S_RUN) && pend_reg && (mode_reg != MV_FIND))
        begin
            ram_we = 1'b1;
        end
        else if (drain && (mode_reg == MV_UP))
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = val_reg;
        end
        else if (accept && (op_t'(op) == OP_PUSH_BACK) && !is_full)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_a;
            ram_wdata = val_in;
        end
        else if (accept && (op_t'(op) == OP_MODIFY) && pos_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_a;
            ram_wdata = val_in;
        end
    end

    olst_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            pend_reg <= issue;
            if (issue)
            begin
                pend_addr_reg <= pend_next;
                rd_addr_reg   <= rd_next;
                rem_reg       <= rem_reg - 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        val_reg          <= val_in;
                        pos_reg          <= pos_a;
                        found_reg        <= '0;
                        status_reg       <= STAT_OK;
                        result_count_reg <= COUNT_W'(count_reg);
                        done_reg         <= 1'b1;
                        unique case (op_t'(op))
                            OP_PUSH_BACK:
                            begin
                                if (is_full)
                                begin
                                    status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    count_reg        <= count_inc;
                                    result_count_reg <= COUNT_W'(count_inc);
                                end
                            end
                            OP_PUSH_FRONT:
                            begin
                                if (is_full)
                                begin
                                    status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    count_reg        <= count_inc;
                                    result_count_reg <= COUNT_W'(count_inc);
                                    pos_reg          <= '0;
                                    mode_reg         <= MV_UP;
                                    rem_reg          <= count_reg;
                                    rd_addr_reg      <= count_m1_a;
                                    state_reg        <= S_RUN;
                                    done_reg         <= 1'b0;
                                end
                            end
                            OP_POP_BACK:
                            begin
                                if (is_empty)
                                begin
                                    status_reg <= STAT_EMPTY;
                                end
                                else
                                begin
                                    count_reg        <= count_dec;
                                    result_count_reg <= COUNT_W'(count_dec);
                                end
                            end
                            OP_POP_FRONT:
                            begin
                                if (is_empty)
                                begin
                                    status_reg <= STAT_EMPTY;
                                end
                                else
                                begin
                                    count_reg        <= count_dec;
                                    result_count_reg <= COUNT_W'(count_dec);
                                    mode_reg         <= MV_DOWN;
                                    rem_reg          <= count_dec;
                                    rd_addr_reg      <= AW'(1);
                                    state_reg        <= S_RUN;
                                    done_reg         <= 1'b0;
                                end
                            end
                            OP_INSERT:
                            begin
                                if (!pos_ok)
                                begin
                                    status_reg <= STAT_RANGE;
                                end
                                else if (is_full)
                                begin
                                    status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    count_reg        <= count_inc;
                                    result_count_reg <= COUNT_W'(count_inc);
                                    mode_reg         <= MV_UP;
                                    rem_reg          <= count_reg - pos_c;
                                    rd_addr_reg      <= count_m1_a;
                                    state_reg        <= S_RUN;
                                    done_reg         <= 1'b0;
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (!pos_ok)
                                begin
                                    status_reg <= STAT_RANGE;
                                end
                                else
                                begin
                                    count_reg        <= count_dec;
                                    result_count_reg <= COUNT_W'(count_dec);
                                    mode_reg         <= MV_DOWN;
                                    rem_reg          <= count_dec - pos_c;
                                    rd_addr_reg      <= pos_a + AW'(1);
                                    state_reg        <= S_RUN;
                                    done_reg         <= 1'b0;
                                end
                            end
                            OP_FIND:
                            begin
                                if (is_empty)
                                begin
                                    status_reg <= STAT_NOTFOUND;
                                end
                                else
                                begin
                                    mode_reg    <= MV_FIND;
                                    rem_reg     <= count_reg;
                                    rd_addr_reg <= '0;
                                    state_reg   <= S_RUN;
                                    done_reg    <= 1'b0;
                                end
                            end
                            OP_MODIFY:
                            begin
                                if (!pos_ok)
                                begin
                                    status_reg <= STAT_RANGE;
                                end
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (match)
                    begin
                        found_reg <= FOUND_W'(pend_addr_reg);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (drain)
                    begin
                        if (mode_reg == MV_FIND)
                        begin
                            status_reg <= STAT_NOTFOUND;
                        end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_index   = found_reg;
    assign element_count = result_count_reg;

    `ASSERT_NEVER(a_count_bound, count_reg > CW'(CAPACITY), "entry count above capacity")
    `ASSERT_CLK(a_issue_pend, (state_reg == S_RUN && rem_reg != '0) |=> pend_reg, "read lost")
    `ASSERT_CLK(a_pend_busy, pend_reg |-> $past(busy), "read issued outside a walk")
    `ASSERT_CLK(a_notfound_zero, (done_reg && status_reg == STAT_NOTFOUND) |-> found_reg == '0, "failed find with nonzero index")

endmodule

// ===== verif/ordered_list_store_tb.sv =====
// ---------------------------------------------------------------------------
// ordered_list_store_tb
// Self-checking bench for the ordered list store. A driver sends request
// beats from a queue with random gaps, a shadow copy of the list predicts
// every result beat, and a monitor checks each result field against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_store_tb;

    import olst_pkg::*;

    localparam int TAIL_CYCLES    = CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        op_t                op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        int                 gap;
    } list_req_t;

    typedef struct {
        status_t            st;
        logic [FOUND_W-1:0] idx;
        logic [COUNT_W-1:0] cnt;
    } list_reply_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           op;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic [FOUND_W-1:0]        found_index;
    logic [COUNT_W-1:0]        element_count;

    list_req_t   req_queue[$];
    list_reply_t reply_queue[$];

    logic [VALUE_W-1:0] shadow_list[CAPACITY];
    int                 shadow_count;
    int                 gen_count;
    int                 req_total;
    int                 mismatch_count;
    int                 idle_cycles;

    list_req_t staged;
    logic      have_staged;
    int        gap_left;
    int        driven_total   = 0;
    int        accepted_total = 0;
    logic      next_start;

    ordered_list_store u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .position     (position),
        .item_value   (item_value),
        .done         (done),
        .status       (status),
        .found_index  (found_index),
        .element_count(element_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic list_reply_t apply_list_request(op_t req_op, logic [POS_W-1:0] pos,
                                                       logic [VALUE_W-1:0] val);
        list_reply_t r;
        int k;
        r.st  = STAT_OK;
        r.idx = '0;
        case (req_op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (shadow_count >= CAPACITY)
                    r.st = STAT_FULL;
                else
                begin
                    if (req_op == OP_PUSH_BACK)
                        shadow_list[shadow_count] = val;
                    else
                    begin
                        for (k = shadow_count; k > 0; k--)
                            shadow_list[k] = shadow_list[k-1];
                        shadow_list[0] = val;
                    end
                    shadow_count++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (shadow_count == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    if (req_op == OP_POP_FRONT)
                        for (k = 1; k < shadow_count; k++)
                            shadow_list[k-1] = shadow_list[k];
                    shadow_count--;
                end
            end
            OP_INSERT:
            begin
                if (int'(pos) >= shadow_count)
                    r.st = STAT_RANGE;
                else if (shadow_count >= CAPACITY)
                    r.st = STAT_FULL;
                else
                begin
                    for (k = shadow_count; k > int'(pos); k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[pos] = val;
                    shadow_count++;
                end
            end
            OP_REMOVE:
            begin
                if (int'(pos) >= shadow_count)
                    r.st = STAT_RANGE;
                else
                begin
                    for (k = int'(pos) + 1; k < shadow_count; k++)
                        shadow_list[k-1] = shadow_list[k];
                    shadow_count--;
                end
            end
            OP_FIND:
            begin
                r.st = STAT_NOTFOUND;
                for (k = 0; k < shadow_count; k++)
                begin
                    if (r.st == STAT_NOTFOUND && shadow_list[k] == val)
                    begin
                        r.st  = STAT_OK;
                        r.idx = k[FOUND_W-1:0];
                    end
                end
            end
            default:
            begin
                if (int'(pos) >= shadow_count)
                    r.st = STAT_RANGE;
                else
                    shadow_list[pos] = val;
            end
        endcase
        r.cnt = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    // Only the count is tracked while building stimulus, so positions can aim
    // inside, at and past the end of the list.
    function automatic int count_after(op_t req_op, logic [POS_W-1:0] pos, int cnt);
        case (req_op)
            OP_PUSH_BACK, OP_PUSH_FRONT: return (cnt < CAPACITY) ? cnt + 1 : cnt;
            OP_POP_BACK, OP_POP_FRONT:   return (cnt > 0) ? cnt - 1 : cnt;
            OP_INSERT: return (int'(pos) < cnt && cnt < CAPACITY) ? cnt + 1 : cnt;
            OP_REMOVE: return (int'(pos) < cnt) ? cnt - 1 : cnt;
            default:   return cnt;
        endcase
    endfunction

    task automatic add_req(op_t req_op, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
        list_req_t r;
        r.op  = req_op;
        r.pos = pos;
        r.val = val;
        // Every fourth window of 40 beats runs with no gaps at all.
        r.gap = ((req_total / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
        req_queue.push_back(r);
        gen_count = count_after(req_op, pos, gen_count);
        req_total++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return VALUE_W'($urandom_range(0, 7)) - VALUE_W'(3);
        else if (r == 5)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int p;
        if ($urandom_range(0, 3) == 0)
            p = $urandom_range(0, 255);
        else
            p = $urandom_range(0, gen_count);
        return (p > 255) ? 8'd255 : p[POS_W-1:0];
    endfunction

    // Lean 0 draws any operation, lean 1 favors growing the list and lean 2
    // favors shrinking it.
    function automatic op_t pick_op(int lean);
        int r;
        r = $urandom_range(0, 99);
        if (lean == 1 && r < 85)
        begin
            case ($urandom_range(0, 2))
                0: return OP_PUSH_BACK;
                1: return OP_PUSH_FRONT;
                default: return OP_INSERT;
            endcase
        end
        if (lean == 2 && r < 70)
        begin
            case ($urandom_range(0, 3))
                0, 1: return OP_POP_BACK;
                2: return OP_POP_FRONT;
                default: return OP_REMOVE;
            endcase
        end
        return op_t'($urandom_range(0, 7));
    endfunction

    task automatic add_random(int lean);
        op_t o;
        o = pick_op(lean);
        add_req(o, pick_pos(), pick_value());
    endtask

    task automatic report_mismatch(string name, int exp_v, int act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        mismatch_count++;
    endtask

    // Driver: inputs change on the falling edge. A beat on the bus has been
    // taken once the monitor has counted as many acceptances as beats sent.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            next_start = start;
            if (start && (accepted_total == driven_total))
            begin
                next_start = 1'b0;
            end
            if (!next_start && !have_staged && req_queue.size() > 0)
            begin
                staged      = req_queue.pop_front();
                have_staged = 1'b1;
                gap_left    = staged.gap;
            end
            if (!next_start && have_staged)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    op          <= staged.op;
                    position    <= staged.pos;
                    item_value  <= staged.val;
                    next_start  = 1'b1;
                    have_staged = 1'b0;
                    driven_total++;
                end
            end
            start <= next_start;
        end
    end

    // Monitor: results are checked before the beat accepted at the same edge
    // is predicted, so a stray result cannot pair with the newest request.
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (reply_queue.size() == 0)
                begin
                    $display("%0t: result beat with none expected, status %0d count %0d",
                             $time, status, element_count);
                    mismatch_count++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", want.st, status);
                    if (found_index !== want.idx)
                        report_mismatch("found_index", want.idx, found_index);
                    if (element_count !== want.cnt)
                        report_mismatch("element_count", want.cnt, element_count);
                end
            end
            if (start && !busy)
            begin
                reply_queue.push_back(apply_list_request(op_t'(op), position, item_value));
                accepted_total++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n          = 1'b0;
        start          = 1'b0;
        op             = '0;
        position       = '0;
        item_value     = '0;
        shadow_count   = 0;
        gen_count      = 0;
        req_total      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        have_staged    = 1'b0;
        gap_left       = 0;

        // Empty list: every operation that needs an entry is refused.
        add_req(OP_POP_BACK, 8'd0, 32'h0);
        add_req(OP_POP_FRONT, 8'd0, 32'h0);
        add_req(OP_REMOVE, 8'd0, 32'h0);
        add_req(OP_MODIFY, 8'd0, 32'h1234_5678);
        add_req(OP_INSERT, 8'd0, 32'h1);
        add_req(OP_FIND, 8'd0, 32'h0);
        add_req(OP_PUSH_BACK, 8'd0, 32'h7FFF_FFFF);
        add_req(OP_PUSH_FRONT, 8'd255, 32'h8000_0000);
        add_req(OP_PUSH_BACK, 8'd0, 32'hFFFF_FFFF);
        add_req(OP_PUSH_BACK, 8'd0, 32'h0000_0000);
        add_req(OP_INSERT, 8'd1, 32'h5555_5555);
        add_req(OP_FIND, 8'd0, 32'hFFFF_FFFF);
        add_req(OP_FIND, 8'd0, 32'hAAAA_AAAA);
        add_req(OP_MODIFY, 8'd2, 32'hAAAA_AAAA);
        add_req(OP_FIND, 8'd0, 32'hAAAA_AAAA);
        add_req(OP_MODIFY, 8'd5, 32'h0);
        add_req(OP_REMOVE, 8'd0, 32'h0);
        add_req(OP_REMOVE, 8'd255, 32'h0);
        add_req(OP_INSERT, 8'd255, 32'h0);
        add_req(OP_INSERT, 8'd4, 32'h0);
        add_req(OP_POP_FRONT, 8'd0, 32'hFFFF_FFFF);
        add_req(OP_POP_BACK, 8'd0, 32'h0);

        for (i = 0; i < 100; i++)
            add_random((gen_count < 12) ? 1 : 0);
        while (gen_count < CAPACITY)
            add_random(1);
        for (i = 0; i < 40; i++)
            add_random(1);
        for (i = 0; i < 150; i++)
            add_random(2);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_queue.size() != 0 || have_staged || start)
            @(posedge clk);
        while (reply_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== ordered_list_store.f =====
+incdir+rtl/core
rtl/core/olst_pkg.sv
rtl/core/olst_ram.sv
rtl/core/ordered_list_store.sv
verif/ordered_list_store_tb.sv
